FILE: hw/rtl/qpt_pkg.sv
package qpt_pkg;

    localparam int COORD_WIDTH        = 32;
    localparam int SCALE_WIDTH        = 16;
    localparam int SCALE_FRAC         = 8;
    localparam int SCALE_PACKED_WIDTH = 3 * SCALE_WIDTH;
    localparam int Q_WIDTH            = 16;
    localparam int ROT_FRAC           = 14;
    localparam int CFG_INDEX_WIDTH    = 4;
    localparam int CFG_DATA_WIDTH     = 48;

    // intermediate widths
    localparam int SP_WIDTH = COORD_WIDTH + SCALE_WIDTH;
    localparam int S_WIDTH  = SP_WIDTH - SCALE_FRAC;
    localparam int TP_WIDTH = S_WIDTH + Q_WIDTH;
    localparam int TR_WIDTH = TP_WIDTH - ROT_FRAC;
    localparam int T_WIDTH  = TR_WIDTH + 2;
    localparam int RP_WIDTH = T_WIDTH + Q_WIDTH;
    localparam int RR_WIDTH = RP_WIDTH - ROT_FRAC;
    localparam int R_WIDTH  = RR_WIDTH + 2;
    localparam int V_WIDTH  = R_WIDTH + 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_W    = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_X    = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Y    = CFG_INDEX_WIDTH'(3);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Z    = CFG_INDEX_WIDTH'(4);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = CFG_INDEX_WIDTH'(5);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = CFG_INDEX_WIDTH'(6);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Z = CFG_INDEX_WIDTH'(7);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          clipped;
    } out_t;

    typedef struct packed {
        logic [SCALE_PACKED_WIDTH-1:0] scale_packed;
        logic signed [Q_WIDTH-1:0]     rot_w;
        logic signed [Q_WIDTH-1:0]     rot_x;
        logic signed [Q_WIDTH-1:0]     rot_y;
        logic signed [Q_WIDTH-1:0]     rot_z;
        logic signed [COORD_WIDTH-1:0] offset_x;
        logic signed [COORD_WIDTH-1:0] offset_y;
        logic signed [COORD_WIDTH-1:0] offset_z;
    } cfg_t;

    // identity transform
    localparam cfg_t CFG_RESET = '{
        scale_packed: SCALE_PACKED_WIDTH'(48'h0100_0100_0100),
        rot_w:        Q_WIDTH'(16384),
        rot_x:        '0,
        rot_y:        '0,
        rot_z:        '0,
        offset_x:     '0,
        offset_y:     '0,
        offset_z:     '0
    };

    localparam logic [SP_WIDTH-1:0] HALF_SP = SP_WIDTH'(1) << (SCALE_FRAC - 1);
    localparam logic [TP_WIDTH-1:0] HALF_TP = TP_WIDTH'(1) << (ROT_FRAC - 1);
    localparam logic [RP_WIDTH-1:0] HALF_RP = RP_WIDTH'(1) << (ROT_FRAC - 1);

    // round to nearest, ties toward plus infinity
    function automatic logic signed [S_WIDTH-1:0] round_scale(
        input logic signed [SP_WIDTH-1:0] p
    );
        logic [SP_WIDTH-1:0] sum;
        sum = p + HALF_SP;
        return sum[SP_WIDTH-1:SCALE_FRAC];
    endfunction

    function automatic logic signed [TR_WIDTH-1:0] round_t(
        input logic signed [TP_WIDTH-1:0] p
    );
        logic [TP_WIDTH-1:0] sum;
        sum = p + HALF_TP;
        return sum[TP_WIDTH-1:ROT_FRAC];
    endfunction

    function automatic logic signed [RR_WIDTH-1:0] round_r(
        input logic signed [RP_WIDTH-1:0] p
    );
        logic [RP_WIDTH-1:0] sum;
        sum = p + HALF_RP;
        return sum[RP_WIDTH-1:ROT_FRAC];
    endfunction

endpackage

FILE: hw/rtl/qpt_pipe.sv
module qpt_pipe (
    input  logic          aclk,
    input  logic          aresetn,
    input  qpt_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  qpt_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output qpt_pkg::out_t out_data
);
    import qpt_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;

    logic signed [Q_WIDTH-1:0]     q      [4];
    logic signed [SCALE_WIDTH-1:0] scale  [3];
    logic signed [COORD_WIDTH-1:0] point  [3];
    logic signed [COORD_WIDTH-1:0] offset [3];

    logic signed [SP_WIDTH-1:0]    sp_next [3];
    logic signed [SP_WIDTH-1:0]    sp_reg  [3];
    logic signed [S_WIDTH-1:0]     s       [3];
    logic signed [TP_WIDTH-1:0]    tp_next [3][4];
    logic signed [TP_WIDTH-1:0]    tp_reg  [3][4];
    logic signed [TR_WIDTH-1:0]    tr      [3][4];
    logic signed [T_WIDTH-1:0]     t_next  [4];
    logic signed [T_WIDTH-1:0]     t_reg   [4];
    logic signed [RP_WIDTH-1:0]    rp_next [3][4];
    logic signed [RP_WIDTH-1:0]    rp_reg  [3][4];
    logic signed [RR_WIDTH-1:0]    rr      [3][4];
    logic signed [R_WIDTH-1:0]     r_next  [3];
    logic signed [R_WIDTH-1:0]     r_reg   [3];
    logic signed [V_WIDTH-1:0]     v       [3];
    logic signed [COORD_WIDTH-1:0] o       [3];
    logic [2:0]                    clip;
    out_t                          out_next;
    out_t                          out_reg;

    // a stage advances when it is empty or the next one advances
    always_comb begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = out_reg;

    always_comb begin
        q[0] = cfg.rot_w;
        q[1] = cfg.rot_x;
        q[2] = cfg.rot_y;
        q[3] = cfg.rot_z;
        for (int i = 0; i < 3; i++) begin
            scale[i] = cfg.scale_packed[i*SCALE_WIDTH +: SCALE_WIDTH];
        end
        point[0]  = in_data.point_x;
        point[1]  = in_data.point_y;
        point[2]  = in_data.point_z;
        offset[0] = cfg.offset_x;
        offset[1] = cfg.offset_y;
        offset[2] = cfg.offset_z;
    end

    // scale products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sp_next[i] = SP_WIDTH'(point[i]) * SP_WIDTH'(scale[i]);
        end
    end

    // q * (0,s) products, tp[i][j] = s_i * q_j
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = round_scale(sp_reg[i]);
            for (int j = 0; j < 4; j++) begin
                tp_next[i][j] = TP_WIDTH'(s[i]) * TP_WIDTH'(q[j]);
            end
        end
    end

    // sum to t
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
                tr[i][j] = round_t(tp_reg[i][j]);
            end
        end
        t_next[0] = -T_WIDTH'(tr[0][1]) - T_WIDTH'(tr[1][2]) - T_WIDTH'(tr[2][3]);
        t_next[1] =  T_WIDTH'(tr[0][0]) + T_WIDTH'(tr[2][2]) - T_WIDTH'(tr[1][3]);
        t_next[2] =  T_WIDTH'(tr[1][0]) - T_WIDTH'(tr[2][1]) + T_WIDTH'(tr[0][3]);
        t_next[3] =  T_WIDTH'(tr[2][0]) + T_WIDTH'(tr[1][1]) - T_WIDTH'(tr[0][2]);
    end

    // t * conj(q) products, rp[i][k] = t_k * q_(k xor (i+1))
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 4; k++) begin
                rp_next[i][k] = RP_WIDTH'(t_reg[k]) * RP_WIDTH'(q[2'(k) ^ 2'(i + 1)]);
            end
        end
    end

    // sum to r
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 4; k++) begin
                rr[i][k] = round_r(rp_reg[i][k]);
            end
        end
        r_next[0] = -R_WIDTH'(rr[0][0]) + R_WIDTH'(rr[0][1])
                    - R_WIDTH'(rr[0][2]) + R_WIDTH'(rr[0][3]);
        r_next[1] = -R_WIDTH'(rr[1][0]) + R_WIDTH'(rr[1][1])
                    + R_WIDTH'(rr[1][2]) - R_WIDTH'(rr[1][3]);
        r_next[2] = -R_WIDTH'(rr[2][0]) - R_WIDTH'(rr[2][1])
                    + R_WIDTH'(rr[2][2]) + R_WIDTH'(rr[2][3]);
    end

    // translate and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v[i] = V_WIDTH'(r_reg[i]) + V_WIDTH'(offset[i]);
            if ((&v[i][V_WIDTH-1:COORD_WIDTH-1]) || !(|v[i][V_WIDTH-1:COORD_WIDTH-1])) begin
                o[i]    = v[i][COORD_WIDTH-1:0];
                clip[i] = 1'b0;
            end else if (v[i][V_WIDTH-1]) begin
                o[i]    = {1'b1, {(COORD_WIDTH-1){1'b0}}};
                clip[i] = 1'b1;
            end else begin
                o[i]    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
                clip[i] = 1'b1;
            end
        end
        out_next.out_x   = o[0];
        out_next.out_y   = o[1];
        out_next.out_z   = o[2];
        out_next.clipped = |clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sp_reg <= sp_next;
        end
        if (en[1]) begin
            tp_reg <= tp_next;
        end
        if (en[2]) begin
            t_reg <= t_next;
        end
        if (en[3]) begin
            rp_reg <= rp_next;
        end
        if (en[4]) begin
            r_reg <= r_next;
        end
        if (en[5]) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: hw/rtl/quaternion_point_transform.sv
// Scales each Q16.16 point per axis, rotates it by the configured quaternion
// as q * (0,v) * conj(q), adds the translation and saturates each coordinate,
// setting clipped when any coordinate saturated. The quaternion is not
// normalized, so a non-unit q also scales the result by |q|^2. One item is
// accepted per cycle while the result side does not stall; each point passes
// through six register stages (scale product, first rotation products,
// first sums, second rotation products, second sums, translate and
// saturate). Stalls on the result side fill empty stages first and hold the
// rest. Configuration writes take effect at once and are meant for times
// when no item is in flight; the configuration port is always ready.
module quaternion_point_transform (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  qpt_pkg::in_t                          s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output qpt_pkg::out_t                         m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qpt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [qpt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import qpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SCALE: begin
                    cfg_next.scale_packed = cfg_data[SCALE_PACKED_WIDTH-1:0];
                end
                REG_ROT_W: begin
                    cfg_next.rot_w = cfg_data[Q_WIDTH-1:0];
                end
                REG_ROT_X: begin
                    cfg_next.rot_x = cfg_data[Q_WIDTH-1:0];
                end
                REG_ROT_Y: begin
                    cfg_next.rot_y = cfg_data[Q_WIDTH-1:0];
                end
                REG_ROT_Z: begin
                    cfg_next.rot_z = cfg_data[Q_WIDTH-1:0];
                end
                REG_OFFSET_X: begin
                    cfg_next.offset_x = cfg_data[COORD_WIDTH-1:0];
                end
                REG_OFFSET_Y: begin
                    cfg_next.offset_y = cfg_data[COORD_WIDTH-1:0];
                end
                REG_OFFSET_Z: begin
                    cfg_next.offset_z = cfg_data[COORD_WIDTH-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qpt_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

FILE: test/quaternion_point_transform_test.sv
module quaternion_point_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qpt_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_STALL = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [COORD_WIDTH-1:0] POS_LIMIT = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] NEG_LIMIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    class transformed_point_board;
        cfg_t regs;
        out_t pending_points[$];
        int errors;

        function new();
            regs = CFG_RESET;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                     logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                REG_SCALE: regs.scale_packed = value[SCALE_PACKED_WIDTH-1:0];
                REG_ROT_W: regs.rot_w = value[Q_WIDTH-1:0];
                REG_ROT_X: regs.rot_x = value[Q_WIDTH-1:0];
                REG_ROT_Y: regs.rot_y = value[Q_WIDTH-1:0];
                REG_ROT_Z: regs.rot_z = value[Q_WIDTH-1:0];
                REG_OFFSET_X: regs.offset_x = value[COORD_WIDTH-1:0];
                REG_OFFSET_Y: regs.offset_y = value[COORD_WIDTH-1:0];
                REG_OFFSET_Z: regs.offset_z = value[COORD_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // v * f / 2^k rounded to nearest, ties toward plus infinity
        static function longint round_mul(longint v, longint f, int k);
            return (v * f + (longint'(1) <<< (k - 1))) >>> k;
        endfunction

        function out_t transform_point(in_t p);
            longint sx, sy, sz, qw, qx, qy, qz;
            longint t0, t1, t2, t3, v, hi, lo;
            longint r[3];
            longint off[3];
            logic [COORD_WIDTH-1:0] c[3];
            out_t res;
            bit clip;
            hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
            lo = -hi - 1;
            clip = 1'b0;
            sx = round_mul($signed(p.point_x),
                           $signed(regs.scale_packed[SCALE_WIDTH-1:0]), SCALE_FRAC);
            sy = round_mul($signed(p.point_y),
                           $signed(regs.scale_packed[2*SCALE_WIDTH-1:SCALE_WIDTH]),
                           SCALE_FRAC);
            sz = round_mul($signed(p.point_z),
                           $signed(regs.scale_packed[3*SCALE_WIDTH-1:2*SCALE_WIDTH]),
                           SCALE_FRAC);
            qw = $signed(regs.rot_w);
            qx = $signed(regs.rot_x);
            qy = $signed(regs.rot_y);
            qz = $signed(regs.rot_z);
            // q * (0, s)
            t0 = -round_mul(sx, qx, ROT_FRAC) - round_mul(sy, qy, ROT_FRAC)
                 - round_mul(sz, qz, ROT_FRAC);
            t1 = round_mul(sx, qw, ROT_FRAC) + round_mul(sz, qy, ROT_FRAC)
                 - round_mul(sy, qz, ROT_FRAC);
            t2 = round_mul(sy, qw, ROT_FRAC) - round_mul(sz, qx, ROT_FRAC)
                 + round_mul(sx, qz, ROT_FRAC);
            t3 = round_mul(sz, qw, ROT_FRAC) + round_mul(sy, qx, ROT_FRAC)
                 - round_mul(sx, qy, ROT_FRAC);
            // vector part of t * conj(q)
            r[0] = -round_mul(t0, qx, ROT_FRAC) + round_mul(t1, qw, ROT_FRAC)
                   - round_mul(t2, qz, ROT_FRAC) + round_mul(t3, qy, ROT_FRAC);
            r[1] = -round_mul(t0, qy, ROT_FRAC) + round_mul(t1, qz, ROT_FRAC)
                   + round_mul(t2, qw, ROT_FRAC) - round_mul(t3, qx, ROT_FRAC);
            r[2] = -round_mul(t0, qz, ROT_FRAC) - round_mul(t1, qy, ROT_FRAC)
                   + round_mul(t2, qx, ROT_FRAC) + round_mul(t3, qw, ROT_FRAC);
            off[0] = $signed(regs.offset_x);
            off[1] = $signed(regs.offset_y);
            off[2] = $signed(regs.offset_z);
            for (int i = 0; i < 3; i++) begin
                v = r[i] + off[i];
                if (v > hi) begin
                    v = hi;
                    clip = 1'b1;
                end else if (v < lo) begin
                    v = lo;
                    clip = 1'b1;
                end
                c[i] = COORD_WIDTH'(v);
            end
            res.out_x = c[0];
            res.out_y = c[1];
            res.out_z = c[2];
            res.clipped = clip;
            return res;
        endfunction

        function void note_point(in_t p);
            pending_points.push_back(transform_point(p));
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_point(out_t got);
            out_t want;
            if (pending_points.size() == 0) begin
                report($sformatf("result %h with no point pending", got));
            end else begin
                want = pending_points.pop_front();
                if (got.out_x !== want.out_x)
                    report($sformatf("out_x got %h want %h", got.out_x, want.out_x));
                if (got.out_y !== want.out_y)
                    report($sformatf("out_y got %h want %h", got.out_y, want.out_y));
                if (got.out_z !== want.out_z)
                    report($sformatf("out_z got %h want %h", got.out_z, want.out_z));
                if (got.clipped !== want.clipped)
                    report($sformatf("clipped got %b want %b", got.clipped, want.clipped));
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    transformed_point_board points;
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    quaternion_point_transform DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: check, then pick ready for the next cycle
    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready === 1'b1)
            points.check_point(m_data);
        if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            hold_left = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_t make_point(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                                       logic [COORD_WIDTH-1:0] z);
        in_t p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    function automatic cfg_t make_setting(logic [SCALE_PACKED_WIDTH-1:0] sc,
                                          logic [Q_WIDTH-1:0] w, logic [Q_WIDTH-1:0] x,
                                          logic [Q_WIDTH-1:0] y, logic [Q_WIDTH-1:0] z,
                                          logic [COORD_WIDTH-1:0] ox,
                                          logic [COORD_WIDTH-1:0] oy,
                                          logic [COORD_WIDTH-1:0] oz);
        cfg_t c;
        c.scale_packed = sc;
        c.rot_w = w;
        c.rot_x = x;
        c.rot_y = y;
        c.rot_z = z;
        c.offset_x = ox;
        c.offset_y = oy;
        c.offset_z = oz;
        return c;
    endfunction

    function automatic cfg_t random_setting(bit full);
        cfg_t c;
        if (full) begin
            c.scale_packed = {16'($urandom), $urandom};
            c.rot_w = 16'($urandom);
            c.rot_x = 16'($urandom);
            c.rot_y = 16'($urandom);
            c.rot_z = 16'($urandom);
            c.offset_x = $urandom;
            c.offset_y = $urandom;
            c.offset_z = $urandom;
        end else begin
            c.scale_packed = {16'($urandom_range(0, 1023) - 512),
                              16'($urandom_range(0, 1023) - 512),
                              16'($urandom_range(0, 1023) - 512)};
            c.rot_w = 16'($urandom_range(0, 32767) - 16384);
            c.rot_x = 16'($urandom_range(0, 32767) - 16384);
            c.rot_y = 16'($urandom_range(0, 32767) - 16384);
            c.rot_z = 16'($urandom_range(0, 32767) - 16384);
            c.offset_x = 32'($urandom_range(0, 2**27 - 1) - 2**26);
            c.offset_y = 32'($urandom_range(0, 2**27 - 1) - 2**26);
            c.offset_z = 32'($urandom_range(0, 2**27 - 1) - 2**26);
        end
        return c;
    endfunction

    function automatic in_t random_point();
        if ($urandom_range(99) < 30)
            return make_point($urandom, $urandom, $urandom);
        return make_point(32'($urandom_range(0, 2**25 - 1) - 2**24),
                          32'($urandom_range(0, 2**25 - 1) - 2**24),
                          32'($urandom_range(0, 2**25 - 1) - 2**24));
    endfunction

    // valid stays high after the item so that a following call keeps it up
    task automatic send_point(input in_t p);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (s_ready !== 1'b1);
        points.note_point(p);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        points.write_register(idx, value);
    endtask

    // junk in the upper bits and a write to an unused index must not matter
    task automatic apply_setting(input cfg_t c);
        write_reg(REG_SCALE, c.scale_packed);
        write_reg(REG_ROT_W, {32'($urandom), c.rot_w});
        write_reg(REG_ROT_X, {32'($urandom), c.rot_x});
        write_reg(REG_ROT_Y, {32'($urandom), c.rot_y});
        write_reg(REG_ROT_Z, {32'($urandom), c.rot_z});
        write_reg(REG_OFFSET_X, {16'($urandom), c.offset_x});
        write_reg(REG_OFFSET_Y, {16'($urandom), c.offset_y});
        write_reg(REG_OFFSET_Z, {16'($urandom), c.offset_z});
        write_reg(CFG_INDEX_WIDTH'($urandom_range(8, 15)), {16'($urandom), $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (points.pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        points = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity transform out of reset
        send_point(make_point('0, '0, '0));
        send_point(make_point(POS_LIMIT, POS_LIMIT, POS_LIMIT));
        send_point(make_point(NEG_LIMIT, NEG_LIMIT, NEG_LIMIT));
        send_point(make_point(32'sd1, -32'sd1, 32'h0000_8000));
        send_point(make_point(POS_LIMIT, NEG_LIMIT, 32'sd1));
        send_point(make_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0001));
        s_valid <= 1'b0;
        wait_for_results();

        // largest scales, non-unit quaternion, largest offsets
        apply_setting(make_setting(48'h7FFF_7FFF_7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                                   16'h8000, POS_LIMIT, POS_LIMIT, POS_LIMIT));
        send_point(make_point(POS_LIMIT, POS_LIMIT, POS_LIMIT));
        send_point(make_point(NEG_LIMIT, NEG_LIMIT, NEG_LIMIT));
        send_point(make_point('0, '0, '0));
        send_point(make_point(32'sd1, 32'sd1, 32'sd1));
        send_point(make_point(-32'sd1, POS_LIMIT, NEG_LIMIT));
        s_valid <= 1'b0;
        wait_for_results();

        // most negative everything
        apply_setting(make_setting(48'h8000_8000_8000, 16'h8000, 16'h8000, 16'h8000,
                                   16'h8000, NEG_LIMIT, NEG_LIMIT, NEG_LIMIT));
        send_point(make_point(POS_LIMIT, POS_LIMIT, POS_LIMIT));
        send_point(make_point(NEG_LIMIT, NEG_LIMIT, NEG_LIMIT));
        send_point(make_point('0, '0, '0));
        send_point(make_point(32'h0001_0000, -32'sd65536, 32'sd3));
        s_valid <= 1'b0;
        wait_for_results();

        // quarter turn about z at half scale, odd inputs land on rounding ties
        apply_setting(make_setting(48'h0080_0080_0080, 16'd11585, '0, '0, 16'd11585,
                                   32'sd1, -32'sd1, 32'h0001_0000));
        send_point(make_point(32'sd1, 32'sd1, 32'sd1));
        send_point(make_point(-32'sd1, -32'sd1, -32'sd1));
        send_point(make_point(32'sd3, -32'sd3, 32'sd5));
        send_point(make_point(32'h0001_0000, '0, '0));
        send_point(make_point('0, 32'h0001_0000, 32'h7FFF_FFFF));
        send_point(make_point(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F));
        s_valid <= 1'b0;
        wait_for_results();

        // zero quaternion leaves only the offset
        apply_setting(make_setting(48'h0100_0100_0100, '0, '0, '0, '0,
                                   32'h1234_5678, -32'sd5, '0));
        send_point(make_point(POS_LIMIT, NEG_LIMIT, 32'h0BAD_F00D));
        send_point(make_point(32'sd7, 32'sd8, 32'sd9));
        s_valid <= 1'b0;
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 31;
                    recv_idle_pct = 70;
                end
                1: begin
                    sender_idle_pct = 70;
                    recv_idle_pct = 31;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                wait_for_results();
                apply_setting(random_setting(seg % 2 == 1));
                for (int n = 0; n < 60; n++) begin
                    // receiver holds off while points keep coming
                    if (phase == 2 && seg == 1 && n == 5)
                        stall_requests++;
                    send_point(random_point());
                end
                s_valid <= 1'b0;
            end
        end

        wait_for_results();
        if (points.errors == 0 && points.pending_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: quaternion_point_transform.f
hw/rtl/qpt_pkg.sv
hw/rtl/qpt_pipe.sv
hw/rtl/quaternion_point_transform.sv
test/quaternion_point_transform_test.sv
